FILE: rtl/core/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, request and status codes,
// table entry layout and sequencer states. Depends on nothing.
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int HEAP_BYTES  = 65536;
   localparam int CHUNK_SLOTS = 64;
   localparam int IDX_W       = $clog2(CHUNK_SLOTS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ADDR_W      = 16;
   localparam int SIZE_W      = 17;

   localparam logic [SIZE_W-1:0] HEAP_SIZE = SIZE_W'(HEAP_BYTES);
   localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(CHUNK_SLOTS);

   typedef enum logic [1:0] {
      K_ALLOC = 2'd0,
      K_FREE  = 2'd1,
      K_RESET = 2'd2,
      K_NOP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_NOT_USED = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT,
      S_MRG_RD,
      S_MRG_EX,
      S_MRG_END,
      S_FIT_RD,
      S_FIT_EX,
      S_FDRP_RD,
      S_FDRP_EX,
      S_UINS_RD,
      S_UINS_EX,
      S_USC_RD,
      S_USC_EX,
      S_FINS_RD,
      S_FINS_EX,
      S_UDRP_RD,
      S_UDRP_EX,
      S_DONE
   } state_type;

endpackage

FILE: rtl/core/first_fit_heap_allocator_top.sv
// First-fit heap allocator: the sequencer, both chunk tables and the result register.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
// Each request word is handled alone; req_stall stays high from acceptance until the
// result word has been loaded into the output register. Both chunk tables live in
// simple dual-port style memories (one write and one registered read a cycle), and
// every table step has a read state that fetches an entry and an act state that
// uses it. An allocate first joins touching free chunks, then runs the first-fit scan;
// when a chunk fits and the used table has room, it closes the gap left in the free
// table if the chunk is consumed whole, then does the sorted insert into the used
// table. A free finds the address in the used table, inserts the chunk into the free
// table when it has room and closes the gap in the used table. A heap reset request
// passes through the INIT state and then DONE. After reset the block spends the INIT
// state writing the single whole-heap free chunk before it takes its first request.
// A zero-size allocate and the unused request kind go straight from idle to DONE.
module first_fit_heap_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [ffha_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_free_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_granted_address
);

   ffha_pkg::state_type state_ff, state_in;

   logic [ffha_pkg::CNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [ffha_pkg::CNT_W-1:0]  ucnt_ff, ucnt_in;
   logic [ffha_pkg::CNT_W-1:0]  ridx_ff, ridx_in;
   logic [ffha_pkg::CNT_W-1:0]  widx_ff, widx_in;
   logic [ffha_pkg::CNT_W-1:0]  hidx_ff, hidx_in;
   logic                        have_ff, have_in;
   logic                        init_rsp_ff, init_rsp_in;
   ffha_pkg::entry_type         pend_ff, pend_in;
   ffha_pkg::entry_type         hit_ff, hit_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [ffha_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [ffha_pkg::ADDR_W-1:0] addr_ff, addr_in;
   ffha_pkg::status_type        stat_ff, stat_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ffha_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [ffha_pkg::ADDR_W-1:0] rsp_grant_ff, rsp_grant_in;

   // Chunk tables, kept sorted by start offset.
   ffha_pkg::entry_type fmem [ffha_pkg::CHUNK_SLOTS];
   ffha_pkg::entry_type umem [ffha_pkg::CHUNK_SLOTS];

   logic                       f_we, u_we;
   logic [ffha_pkg::IDX_W-1:0] f_waddr, f_raddr, u_waddr, u_raddr;
   ffha_pkg::entry_type        f_wdata, u_wdata;
   ffha_pkg::entry_type        f_rdata_ff, u_rdata_ff;

   // Shared step signals.
   logic [ffha_pkg::SIZE_W-1:0] pend_end;
   logic                        touches;
   logic                        fits;
   logic [ffha_pkg::SIZE_W-1:0] tail;
   logic [ffha_pkg::CNT_W-1:0]  ridx_inc, ridx_dec;
   logic                        out_free;
   ffha_pkg::entry_type         new_used;

   assign pend_end = {1'b0, pend_ff.start} + pend_ff.size;
   assign touches  = have_ff && (pend_end == {1'b0, f_rdata_ff.start});
   assign fits     = f_rdata_ff.size >= size_ff;
   assign tail     = f_rdata_ff.size - size_ff;
   assign ridx_inc = ridx_ff + 1'b1;
   assign ridx_dec = ridx_ff - 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign new_used = '{start: hit_ff.start, size: size_ff};

   assign req_stall           = (state_ff != ffha_pkg::S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_grant_ff;

   always_ff @(posedge clock) begin
      if (f_we) begin
         fmem[f_waddr] <= f_wdata;
      end
      f_rdata_ff <= fmem[f_raddr];
   end

   always_ff @(posedge clock) begin
      if (u_we) begin
         umem[u_waddr] <= u_wdata;
      end
      u_rdata_ff <= umem[u_raddr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  ffha_pkg::K_ALLOC: begin
                     state_in = (req_request_size == '0) ? ffha_pkg::S_DONE
                                                         : ffha_pkg::S_MRG_RD;
                  end
                  ffha_pkg::K_FREE:  state_in = ffha_pkg::S_USC_RD;
                  ffha_pkg::K_RESET: state_in = ffha_pkg::S_INIT;
                  default:           state_in = ffha_pkg::S_DONE;
               endcase
            end
         end
         ffha_pkg::S_INIT: begin
            state_in = init_rsp_ff ? ffha_pkg::S_DONE : ffha_pkg::S_IDLE;
         end
         ffha_pkg::S_MRG_RD: begin
            state_in = (ridx_ff == fcnt_ff) ? ffha_pkg::S_MRG_END : ffha_pkg::S_MRG_EX;
         end
         ffha_pkg::S_MRG_EX:  state_in = ffha_pkg::S_MRG_RD;
         ffha_pkg::S_MRG_END: state_in = ffha_pkg::S_FIT_RD;
         ffha_pkg::S_FIT_RD: begin
            state_in = (ridx_ff == fcnt_ff) ? ffha_pkg::S_DONE : ffha_pkg::S_FIT_EX;
         end
         ffha_pkg::S_FIT_EX: begin
            if (!fits) begin
               state_in = ffha_pkg::S_FIT_RD;
            end else if (ucnt_ff == ffha_pkg::SLOTS_CNT) begin
               state_in = ffha_pkg::S_DONE;
            end else if (tail != '0) begin
               state_in = ffha_pkg::S_UINS_RD;
            end else begin
               state_in = ffha_pkg::S_FDRP_RD;
            end
         end
         ffha_pkg::S_FDRP_RD: begin
            state_in = (ridx_inc == fcnt_ff) ? ffha_pkg::S_UINS_RD : ffha_pkg::S_FDRP_EX;
         end
         ffha_pkg::S_FDRP_EX: state_in = ffha_pkg::S_FDRP_RD;
         ffha_pkg::S_UINS_RD: begin
            state_in = (ridx_ff == '0) ? ffha_pkg::S_DONE : ffha_pkg::S_UINS_EX;
         end
         ffha_pkg::S_UINS_EX: begin
            state_in = (u_rdata_ff.start > hit_ff.start) ? ffha_pkg::S_UINS_RD
                                                         : ffha_pkg::S_DONE;
         end
         ffha_pkg::S_USC_RD: begin
            state_in = (ridx_ff == ucnt_ff) ? ffha_pkg::S_DONE : ffha_pkg::S_USC_EX;
         end
         ffha_pkg::S_USC_EX: begin
            if (u_rdata_ff.start != addr_ff) begin
               state_in = ffha_pkg::S_USC_RD;
            end else if (fcnt_ff == ffha_pkg::SLOTS_CNT) begin
               state_in = ffha_pkg::S_DONE;
            end else begin
               state_in = ffha_pkg::S_FINS_RD;
            end
         end
         ffha_pkg::S_FINS_RD: begin
            state_in = (ridx_ff == '0) ? ffha_pkg::S_UDRP_RD : ffha_pkg::S_FINS_EX;
         end
         ffha_pkg::S_FINS_EX: begin
            state_in = (f_rdata_ff.start > hit_ff.start) ? ffha_pkg::S_FINS_RD
                                                         : ffha_pkg::S_UDRP_RD;
         end
         ffha_pkg::S_UDRP_RD: begin
            state_in = (ridx_inc == ucnt_ff) ? ffha_pkg::S_DONE : ffha_pkg::S_UDRP_EX;
         end
         ffha_pkg::S_UDRP_EX: state_in = ffha_pkg::S_UDRP_RD;
         ffha_pkg::S_DONE: begin
            if (out_free) begin
               state_in = ffha_pkg::S_IDLE;
            end
         end
         default: state_in = ffha_pkg::S_IDLE;
      endcase
   end

   // Datapath and table port control.
   always_comb begin
      fcnt_in       = fcnt_ff;
      ucnt_in       = ucnt_ff;
      ridx_in       = ridx_ff;
      widx_in       = widx_ff;
      hidx_in       = hidx_ff;
      have_in       = have_ff;
      init_rsp_in   = init_rsp_ff;
      pend_in       = pend_ff;
      hit_in        = hit_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      stat_in       = stat_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      f_we          = 1'b0;
      f_waddr       = ridx_ff[ffha_pkg::IDX_W-1:0];
      f_wdata       = f_rdata_ff;
      f_raddr       = ridx_ff[ffha_pkg::IDX_W-1:0];
      u_we          = 1'b0;
      u_waddr       = ridx_ff[ffha_pkg::IDX_W-1:0];
      u_wdata       = u_rdata_ff;
      u_raddr       = ridx_ff[ffha_pkg::IDX_W-1:0];

      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in     = req_kind;
               size_in     = req_request_size;
               addr_in     = req_free_address;
               ridx_in     = '0;
               widx_in     = '0;
               have_in     = 1'b0;
               init_rsp_in = 1'b1;
               stat_in     = ((req_kind == ffha_pkg::K_ALLOC) && (req_request_size == '0))
                             ? ffha_pkg::ST_NO_FIT : ffha_pkg::ST_OK;
            end
         end
         ffha_pkg::S_INIT: begin
            f_we    = 1'b1;
            f_waddr = '0;
            f_wdata = '{start: '0, size: ffha_pkg::HEAP_SIZE};
            fcnt_in = ffha_pkg::CNT_W'(1);
            ucnt_in = '0;
            stat_in = ffha_pkg::ST_OK;
         end
         ffha_pkg::S_MRG_EX: begin
            // Grow the pending chunk, or retire it and start a new one.
            if (touches) begin
               pend_in.size = pend_ff.size + f_rdata_ff.size;
            end else begin
               if (have_ff) begin
                  f_we    = 1'b1;
                  f_waddr = widx_ff[ffha_pkg::IDX_W-1:0];
                  f_wdata = pend_ff;
                  widx_in = widx_ff + 1'b1;
               end
               pend_in = f_rdata_ff;
               have_in = 1'b1;
            end
            ridx_in = ridx_inc;
         end
         ffha_pkg::S_MRG_END: begin
            if (have_ff) begin
               f_we    = 1'b1;
               f_waddr = widx_ff[ffha_pkg::IDX_W-1:0];
               f_wdata = pend_ff;
               fcnt_in = widx_ff + 1'b1;
            end else begin
               fcnt_in = widx_ff;
            end
            ridx_in = '0;
         end
         ffha_pkg::S_FIT_RD: begin
            if (ridx_ff == fcnt_ff) begin
               stat_in = ffha_pkg::ST_NO_FIT;
            end
         end
         ffha_pkg::S_FIT_EX: begin
            if (!fits) begin
               ridx_in = ridx_inc;
            end else begin
               hit_in = f_rdata_ff;
               if (ucnt_ff == ffha_pkg::SLOTS_CNT) begin
                  stat_in = ffha_pkg::ST_FULL;
               end else if (tail != '0) begin
                  // The tail keeps the consumed chunk's place in the sorted order.
                  f_we          = 1'b1;
                  f_wdata.start = f_rdata_ff.start + size_ff[ffha_pkg::ADDR_W-1:0];
                  f_wdata.size  = tail;
                  ridx_in       = ucnt_ff;
               end
            end
         end
         ffha_pkg::S_FDRP_RD: begin
            f_raddr = ridx_inc[ffha_pkg::IDX_W-1:0];
            if (ridx_inc == fcnt_ff) begin
               fcnt_in = fcnt_ff - 1'b1;
               ridx_in = ucnt_ff;
            end
         end
         ffha_pkg::S_FDRP_EX: begin
            f_we    = 1'b1;
            ridx_in = ridx_inc;
         end
         ffha_pkg::S_UINS_RD: begin
            u_raddr = ridx_dec[ffha_pkg::IDX_W-1:0];
            if (ridx_ff == '0) begin
               u_we    = 1'b1;
               u_wdata = new_used;
               ucnt_in = ucnt_ff + 1'b1;
               stat_in = ffha_pkg::ST_OK;
            end
         end
         ffha_pkg::S_UINS_EX: begin
            u_we = 1'b1;
            if (u_rdata_ff.start > hit_ff.start) begin
               ridx_in = ridx_dec;
            end else begin
               u_wdata = new_used;
               ucnt_in = ucnt_ff + 1'b1;
               stat_in = ffha_pkg::ST_OK;
            end
         end
         ffha_pkg::S_USC_RD: begin
            if (ridx_ff == ucnt_ff) begin
               stat_in = ffha_pkg::ST_NOT_USED;
            end
         end
         ffha_pkg::S_USC_EX: begin
            if (u_rdata_ff.start != addr_ff) begin
               ridx_in = ridx_inc;
            end else begin
               hit_in  = u_rdata_ff;
               hidx_in = ridx_ff;
               ridx_in = fcnt_ff;
               if (fcnt_ff == ffha_pkg::SLOTS_CNT) begin
                  stat_in = ffha_pkg::ST_FULL;
               end
            end
         end
         ffha_pkg::S_FINS_RD: begin
            f_raddr = ridx_dec[ffha_pkg::IDX_W-1:0];
            if (ridx_ff == '0) begin
               f_we    = 1'b1;
               f_wdata = hit_ff;
               fcnt_in = fcnt_ff + 1'b1;
               ridx_in = hidx_ff;
            end
         end
         ffha_pkg::S_FINS_EX: begin
            f_we = 1'b1;
            if (f_rdata_ff.start > hit_ff.start) begin
               ridx_in = ridx_dec;
            end else begin
               f_wdata = hit_ff;
               fcnt_in = fcnt_ff + 1'b1;
               ridx_in = hidx_ff;
            end
         end
         ffha_pkg::S_UDRP_RD: begin
            u_raddr = ridx_inc[ffha_pkg::IDX_W-1:0];
            if (ridx_inc == ucnt_ff) begin
               ucnt_in = ucnt_ff - 1'b1;
               stat_in = ffha_pkg::ST_OK;
            end
         end
         ffha_pkg::S_UDRP_EX: begin
            u_we    = 1'b1;
            ridx_in = ridx_inc;
         end
         ffha_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_grant_in  = ((kind_ff == ffha_pkg::K_ALLOC) && (stat_ff == ffha_pkg::ST_OK))
                               ? hit_ff.start : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // After reset the sequencer first lays down the whole-heap free chunk.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::S_INIT;
         fcnt_ff      <= '0;
         ucnt_ff      <= '0;
         ridx_ff      <= '0;
         widx_ff      <= '0;
         hidx_ff      <= '0;
         have_ff      <= 1'b0;
         init_rsp_ff  <= 1'b0;
         stat_ff      <= ffha_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fcnt_ff      <= fcnt_in;
         ucnt_ff      <= ucnt_in;
         ridx_ff      <= ridx_in;
         widx_ff      <= widx_in;
         hidx_ff      <= hidx_in;
         have_ff      <= have_in;
         init_rsp_ff  <= init_rsp_in;
         stat_ff      <= stat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      hit_ff        <= hit_in;
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   // Neither table may ever hold more chunks than it has slots.
   a_fcnt_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= ffha_pkg::SLOTS_CNT)
      else $error("free table count beyond its slots");

   a_ucnt_bound: assert property (@(posedge clock) disable iff (reset)
      ucnt_ff <= ffha_pkg::SLOTS_CNT)
      else $error("used table count beyond its slots");

   // A used insert only begins when the used table has room.
   a_uins_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffha_pkg::S_UINS_RD) |-> (ucnt_ff < ffha_pkg::SLOTS_CNT))
      else $error("used insert started on a full table");

   // A finished request with a free output slot reaches the output next cycle.
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffha_pkg::S_DONE && !rsp_valid_ff) |=>
         (rsp_valid_ff && state_ff == ffha_pkg::S_IDLE))
      else $error("result word not delivered");

endmodule
